// ----- hdl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text cursor controller: item layouts,
// command and scroll codes, register indexes.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int DIM_W   = 9;
	localparam int COORD_W = 8;
	localparam int TGT_W   = 16;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [2:0] OP_HOME    = 3'd0;
	localparam logic [2:0] OP_ADVANCE = 3'd1;
	localparam logic [2:0] OP_DOWN    = 3'd2;
	localparam logic [2:0] OP_BACK    = 3'd3;
	localparam logic [2:0] OP_UP      = 3'd4;
	localparam logic [2:0] OP_GOTO    = 3'd5;

	localparam logic [1:0] SCR_NONE = 2'd0;
	localparam logic [1:0] SCR_DOWN = 2'd1;
	localparam logic [1:0] SCR_LEFT = 2'd2;
	localparam logic [1:0] SCR_UP   = 2'd3;

	localparam logic [1:0] REG_WIN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_WIN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_NO_WRAP    = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd80;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd25;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [TGT_W-1:0] target_x;
		logic signed [TGT_W-1:0] target_y;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] cur_col;
		logic [COORD_W-1:0] cur_row;
		logic               accepted;
		logic [1:0]         scroll_req;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             no_wrap;
	} win_cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [1:0]         scroll;
	} cursor_t;

endpackage

// ----- hdl/text_cursor_controller_unit.sv -----
// ----------------------------------------------------------------------------
// text_cursor_controller_unit
// Text cursor controller: keeps a cursor inside a configured window and
// applies one movement command per transfer.
//
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// in       | in_valid, in_ready, in_data      | command transfer in
// out      | out_valid, out_ready, out_data   | result transfer out
// cfg      | psel, penable, pwrite, paddr,    | APB register port
//          | pwdata, prdata, pready           |
//
// From input transfer to result valid: input register, then next-cursor
// logic into the result register; one command per cycle when not stalled.
// The cursor registers update in the same edge that loads the result.
// A held result stalls the input register, which stalls in_ready.
// Reset clears the cursor to (0,0), no scroll, window 80 x 25, wrap on.
// ----------------------------------------------------------------------------
module text_cursor_controller_unit import tcc_pkg::*; #(
	parameter int MAX_DIM = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int DIM_LIM = (MAX_DIM < 256) ? MAX_DIM : 256;

	win_cfg_t  win;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      adv_s1;
	cursor_t   cur_q;
	cursor_t   nxt;
	logic      ok;
	out_item_t res_q;
	logic      res_valid_q;

	tcc_regs #(
		.DIM_LIM (DIM_LIM)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.win     (win)
	);

	tcc_step u_step (
		.item (item_s1),
		.win  (win),
		.cur  (cur_q),
		.nxt  (nxt),
		.ok   (ok)
	);

	assign adv_s1   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				cur_q <= nxt;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q.cur_col    <= nxt.col;
			res_q.cur_row    <= nxt.row;
			res_q.accepted   <= ok;
			res_q.scroll_req <= nxt.scroll;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input stage dropped a held command");

	a_res_matches_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.cur_col == cur_q.col) && (out_data.cur_row == cur_q.row)
			&& (out_data.scroll_req == cur_q.scroll))
		else $error("result disagrees with cursor state");

	a_cursor_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(cur_q))
		else $error("cursor changed without a command");

	a_win_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(win.width != '0) && (win.height != '0))
		else $error("effective window dimension is zero");
`endif

endmodule

// ----- hdl/tcc_regs.sv -----
// ----------------------------------------------------------------------------
// tcc_regs
// Window configuration registers behind the APB port; presents the
// effective window size (zero taken as one, capped at the dimension limit).
// ----------------------------------------------------------------------------
module tcc_regs import tcc_pkg::*; #(
	parameter int DIM_LIM = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output win_cfg_t          win
);

	localparam logic [DIM_W-1:0] LIM = DIM_W'(DIM_LIM);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             no_wrap_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= HEIGHT_RST;
			no_wrap_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WIN_WIDTH:  width_q   <= pwdata[DIM_W-1:0];
				REG_WIN_HEIGHT: height_q  <= pwdata[DIM_W-1:0];
				REG_NO_WRAP:    no_wrap_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIN_WIDTH:  prdata = {{(APB_DW-DIM_W){1'b0}}, width_q};
			REG_WIN_HEIGHT: prdata = {{(APB_DW-DIM_W){1'b0}}, height_q};
			REG_NO_WRAP:    prdata = {{(APB_DW-1){1'b0}}, no_wrap_q};
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0)      win.width = DIM_W'(1);
		else if (width_q > LIM) win.width = LIM;
		else                    win.width = width_q;
		if (height_q == '0)      win.height = DIM_W'(1);
		else if (height_q > LIM) win.height = LIM;
		else                     win.height = height_q;
		win.no_wrap = no_wrap_q;
	end

endmodule

// ----- hdl/tcc_step.sv -----
// ----------------------------------------------------------------------------
// tcc_step
// Next-cursor logic: applies one command to the current cursor and window.
// ----------------------------------------------------------------------------
module tcc_step import tcc_pkg::*; (
	input  in_item_t item,
	input  win_cfg_t win,
	input  cursor_t  cur,
	output cursor_t  nxt,
	output logic     ok
);

	logic [DIM_W-1:0]   col_inc;
	logic [DIM_W-1:0]   row_inc;
	logic [COORD_W-1:0] last_col;
	logic [COORD_W-1:0] last_row;
	logic               tx_in;
	logic               ty_in;

	assign col_inc  = {1'b0, cur.col} + DIM_W'(1);
	assign row_inc  = {1'b0, cur.row} + DIM_W'(1);
	assign last_col = COORD_W'(win.width - DIM_W'(1));
	assign last_row = COORD_W'(win.height - DIM_W'(1));
	assign tx_in    = !item.target_x[TGT_W-1]
		&& ({1'b0, item.target_x[TGT_W-2:0]} < {{(TGT_W-DIM_W){1'b0}}, win.width});
	assign ty_in    = !item.target_y[TGT_W-1]
		&& ({1'b0, item.target_y[TGT_W-2:0]} < {{(TGT_W-DIM_W){1'b0}}, win.height});

	always_comb begin
		nxt = cur;
		ok  = 1'b1;
		case (item.opcode)
			OP_HOME: begin
				nxt.col = '0;
				nxt.row = '0;
			end
			OP_ADVANCE: begin
				nxt.scroll = SCR_NONE;
				if (col_inc >= win.width) begin
					if (win.no_wrap) begin
						ok = 1'b0;
					end else begin
						nxt.col = '0;
						if (row_inc >= win.height) begin
							nxt.scroll = SCR_DOWN;
							ok         = 1'b0;
						end else begin
							nxt.row = row_inc[COORD_W-1:0];
						end
					end
				end else begin
					nxt.col = col_inc[COORD_W-1:0];
				end
			end
			OP_DOWN: begin
				nxt.scroll = SCR_NONE;
				if (row_inc >= win.height) begin
					nxt.row    = last_row;
					nxt.scroll = SCR_DOWN;
					ok         = 1'b0;
				end else begin
					nxt.row = row_inc[COORD_W-1:0];
				end
			end
			OP_BACK: begin
				nxt.scroll = SCR_NONE;
				if (cur.col == '0) begin
					if (win.no_wrap) begin
						nxt.scroll = SCR_LEFT;
						ok         = 1'b0;
					end else begin
						nxt.col = last_col;
						if (cur.row == '0) begin
							nxt.scroll = SCR_UP;
							ok         = 1'b0;
						end else begin
							nxt.row = cur.row - COORD_W'(1);
						end
					end
				end else begin
					nxt.col = cur.col - COORD_W'(1);
				end
			end
			OP_UP: begin
				nxt.scroll = SCR_NONE;
				if (cur.row == '0) begin
					if (win.no_wrap) begin
						nxt.scroll = SCR_UP;
						ok         = 1'b0;
					end else begin
						nxt.row = last_row;
					end
				end else begin
					nxt.row = cur.row - COORD_W'(1);
				end
			end
			OP_GOTO: begin
				if (tx_in && ty_in) begin
					nxt.col = item.target_x[COORD_W-1:0];
					nxt.row = item.target_y[COORD_W-1:0];
				end else begin
					ok = 1'b0;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule
